// File: hdl/lag256_multiply_with_carry_rng_assert.svh
// Assertion helpers; expect clk and rst_n in scope.
`ifndef LAG256_MULTIPLY_WITH_CARRY_RNG_ASSERT_SVH
`define LAG256_MULTIPLY_WITH_CARRY_RNG_ASSERT_SVH
`define LMWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LMWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/lmwc_pkg.sv
package lmwc_pkg;
  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned IDX_W        = $clog2(TABLE_DEPTH);
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned CARRY_W      = 30;
  localparam int unsigned SEED_W       = 64;
  localparam int unsigned WARMUP_DRAWS = 32;
  localparam int unsigned WARM_W       = $clog2(WARMUP_DRAWS + 2);

  localparam logic [1:0] CMD_RESEED  = 2'd0;
  localparam logic [1:0] CMD_ENTROPY = 2'd1;
  localparam logic [1:0] CMD_DRAW    = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [CARRY_W-1:0] MWC_MULT = 30'd809430660;
  localparam logic [16:0]        LCG_MULT = 17'd69069;
  localparam logic [WORD_W-1:0]  LCG_ADD  = 32'd362437;

  // floor(2^64 / MWC_MULT)
  localparam logic [SEED_W-1:0] MWC_RECIP = {SEED_W{1'b1}} / SEED_W'(MWC_MULT);

  typedef struct packed {
    logic              start;
    logic [SEED_W-1:0] operand;
  } mod_req_t;

  typedef struct packed {
    logic               busy;
    logic [CARRY_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [WORD_W-1:0] lcg_next(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] p;
    p = w * WORD_W'(LCG_MULT);
    return p + LCG_ADD;
  endfunction
endpackage

// File: hdl/lmwc_ram.sv
module lmwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// File: hdl/lmwc_mod.sv
module lmwc_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  lmwc_pkg::mod_req_t req,
  output lmwc_pkg::mod_rsp_t rsp
);
  import lmwc_pkg::*;

  localparam int unsigned       HI_W     = 3;
  localparam int unsigned       LH_W     = WORD_W + HI_W;
  localparam int unsigned       SUM_W    = SEED_W + 2;
  localparam logic [WORD_W-1:0] RECIP_LO = MWC_RECIP[WORD_W-1:0];
  localparam logic [HI_W-1:0]   RECIP_HI = MWC_RECIP[WORD_W+HI_W-1:WORD_W];
  localparam logic [WORD_W-1:0] MULT_W   = WORD_W'(MWC_MULT);

  typedef enum logic [2:0] {M_IDLE, M_PROD, M_QUOT, M_BACK, M_FIX} mod_state_t;

  mod_state_t         state_r, state_nxt;
  logic [SEED_W-1:0]  op_r, op_nxt;
  logic [SEED_W-1:0]  ll_r, ll_nxt;
  logic [SEED_W-1:0]  hl_r, hl_nxt;
  logic [LH_W-1:0]    lh_r, lh_nxt;
  logic [WORD_W-1:0]  hh_r, hh_nxt;
  logic [WORD_W-1:0]  q_r, q_nxt;
  logic [WORD_W-1:0]  r_r, r_nxt;
  logic [CARRY_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0]   sum;

  // Barrett reduction: q = floor(x * RECIP / 2^64) is the quotient or one
  // less, so x - q * MWC_MULT fits in 32 bits and needs one subtract at most
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ll_nxt    = ll_r;
    hl_nxt    = hl_r;
    lh_nxt    = lh_r;
    hh_nxt    = hh_r;
    q_nxt     = q_r;
    r_nxt     = r_r;
    rem_nxt   = rem_r;
    sum       = SUM_W'(hl_r) + SUM_W'(lh_r) + SUM_W'(ll_r[SEED_W-1:WORD_W]);
    if (req.start) begin
      op_nxt    = req.operand;
      state_nxt = M_PROD;
    end else begin
      unique case (state_r)
        M_IDLE: ;
        M_PROD: begin
          ll_nxt    = SEED_W'(op_r[WORD_W-1:0]) * SEED_W'(RECIP_LO);
          hl_nxt    = SEED_W'(op_r[SEED_W-1:WORD_W]) * SEED_W'(RECIP_LO);
          lh_nxt    = LH_W'(op_r[WORD_W-1:0]) * LH_W'(RECIP_HI);
          hh_nxt    = op_r[SEED_W-1:WORD_W] * WORD_W'(RECIP_HI);
          state_nxt = M_QUOT;
        end
        M_QUOT: begin
          q_nxt     = hh_r + sum[SEED_W-1:WORD_W];
          state_nxt = M_BACK;
        end
        M_BACK: begin
          r_nxt     = op_r[WORD_W-1:0] - q_r * MULT_W;
          state_nxt = M_FIX;
        end
        M_FIX: begin
          rem_nxt   = (r_r >= MULT_W) ? CARRY_W'(r_r - MULT_W) : r_r[CARRY_W-1:0];
          state_nxt = M_IDLE;
        end
        default: begin
          state_nxt = M_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r  <= op_nxt;
    ll_r  <= ll_nxt;
    hl_r  <= hl_nxt;
    lh_r  <= lh_nxt;
    hh_r  <= hh_nxt;
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = (state_r != M_IDLE);
  assign rsp.rem  = rem_r;
endmodule

// File: hdl/lag256_multiply_with_carry_rng.sv
// Lag-256 multiply-with-carry generator.
// Input channel (in_valid/in_ready): one beat carries in_cmd and in_seed_value.
//   Reseed and entropy commands return nothing; a draw returns one beat on
//   the output channel (out_valid/out_ready) with the word and its parity.
// Draws: the table RAM read is registered, then the multiply-add and
//   write-back of that word follow in S_DMUL; the next command waits for
//   the write-back, which also loads the output register.
// Reseed: a table fill writes all 256 entries, then 32 warm-up draws run;
//   the carry reduction runs under the fill.
// Entropy: 2 draws, then a read-modify-write pass over every entry
//   (S_ERD, S_EWR); the carry reduction runs under the pass.
// in_ready is high only when no command is in progress.
// Reset: carry 0, index 255, then a clearing pass writes zero to every
//   table entry; in_ready stays low during that pass.
// Stall: a user draw finishes and writes back only when the output register
//   is free or being emptied; otherwise it waits, holding its state.
`include "lag256_multiply_with_carry_rng_assert.svh"
module lag256_multiply_with_carry_rng (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [lmwc_pkg::SEED_W-1:0] in_seed_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lmwc_pkg::WORD_W-1:0] out_rand_word,
  output logic                        out_word_parity
);
  import lmwc_pkg::*;

  localparam logic [IDX_W-1:0] IDX_MAX     = IDX_W'(TABLE_DEPTH - 1);
  localparam int unsigned      PROD_W      = WORD_W + CARRY_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DRD, S_DMUL, S_FILL, S_ERD, S_EWR, S_WAIT
  } state_t;

  typedef enum logic [1:0] {DK_USER, DK_WARM, DK_ENT_HI, DK_ENT_LO} draw_kind_t;

  state_t             state_r, state_nxt;
  draw_kind_t         kind_r, kind_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [CARRY_W-1:0] carry_r, carry_nxt;
  logic [SEED_W-1:0]  seed_r, seed_nxt;
  logic [WORD_W-1:0]  hi_r, hi_nxt;
  logic [WORD_W-1:0]  p1_r, p1_nxt;
  logic [WORD_W-1:0]  p2_r, p2_nxt;
  logic [WARM_W-1:0]  warm_r, warm_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_word_r, out_word_nxt;
  logic               out_par_r, out_par_nxt;

  logic               in_fire, rd_issue, out_free;
  logic               draw_fire, user_stall;
  logic [IDX_W-1:0]   idx_inc;
  logic [PROD_W-1:0]  t;
  logic [WORD_W-1:0]  t_lo;
  logic [CARRY_W-1:0] t_hi;
  logic [WORD_W-1:0]  seq_term, fill_word;
  logic [SEED_W-1:0]  s_mix;

  logic               wr_en, rd_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  logic [WORD_W-1:0]  wr_data, rd_data;
  mod_req_t           mod_req;
  mod_rsp_t           mod_rsp;

  lmwc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lmwc_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign draw_fire  = in_fire && in_cmd == CMD_DRAW;
  assign rd_issue   = (state_r == S_DRD) || draw_fire;
  assign idx_inc    = idx_r + 1'b1;
  assign rd_en      = rd_issue || (state_r == S_ERD);
  assign rd_addr    = (state_r == S_ERD) ? ptr_r : idx_inc;
  assign out_free   = !out_valid_r || out_ready;
  assign user_stall = state_r == S_DMUL && kind_r == DK_USER && !out_free;

  assign t    = PROD_W'(MWC_MULT) * PROD_W'(rd_data) + PROD_W'(carry_r);
  assign t_lo = t[WORD_W-1:0];
  assign t_hi = t[PROD_W-1:WORD_W];

  // words 0 and 1 come from the seed, the rest from the word two back
  always_comb begin
    if (ptr_r == IDX_W'(0)) begin
      seq_term  = seed_r[WORD_W-1:0];
      fill_word = seed_r[WORD_W-1:0];
    end else if (ptr_r == IDX_W'(1)) begin
      seq_term  = seed_r[SEED_W-1:WORD_W] ^ seed_r[WORD_W-1:0];
      fill_word = seed_r[SEED_W-1:WORD_W];
    end else begin
      seq_term  = lcg_next(p2_r);
      fill_word = lcg_next(p2_r);
    end
  end

  assign s_mix = seed_r ^ {hi_r, t_lo};

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    carry_nxt     = carry_r;
    seed_nxt      = seed_r;
    hi_nxt        = hi_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    warm_nxt      = warm_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_par_nxt   = out_par_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = '0;
    mod_req       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (rd_issue) begin
      idx_nxt = idx_inc;
    end

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == IDX_MAX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_RESEED: begin
              mod_req.start   = 1'b1;
              mod_req.operand = in_seed_value;
              seed_nxt        = in_seed_value;
              ptr_nxt         = '0;
              warm_nxt        = WARM_W'(WARMUP_DRAWS);
              state_nxt       = S_FILL;
            end
            CMD_ENTROPY: begin
              seed_nxt  = in_seed_value;
              kind_nxt  = DK_ENT_HI;
              state_nxt = S_DRD;
            end
            CMD_DRAW: begin
              kind_nxt  = DK_USER;
              state_nxt = S_DMUL;
            end
            default: ;
          endcase
        end
      end
      S_DRD: begin
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        wr_addr = idx_r;
        wr_data = t_lo;
        unique case (kind_r)
          DK_USER: begin
            if (out_free) begin
              wr_en         = 1'b1;
              carry_nxt     = t_hi;
              out_valid_nxt = 1'b1;
              out_word_nxt  = t_lo;
              out_par_nxt   = ^t_lo;
              state_nxt     = S_IDLE;
            end
          end
          DK_WARM: begin
            wr_en     = 1'b1;
            carry_nxt = t_hi;
            warm_nxt  = warm_r - 1'b1;
            state_nxt = (warm_r == WARM_W'(1)) ? S_IDLE : S_DRD;
          end
          DK_ENT_HI: begin
            wr_en     = 1'b1;
            carry_nxt = t_hi;
            hi_nxt    = t_lo;
            kind_nxt  = DK_ENT_LO;
            state_nxt = S_DRD;
          end
          DK_ENT_LO: begin
            wr_en           = 1'b1;
            carry_nxt       = t_hi;
            seed_nxt        = s_mix;
            mod_req.start   = 1'b1;
            mod_req.operand = s_mix ^ SEED_W'(t_hi);
            ptr_nxt         = '0;
            warm_nxt        = '0;
            state_nxt       = S_ERD;
          end
        endcase
      end
      S_FILL: begin
        wr_en   = 1'b1;
        wr_data = fill_word;
        p2_nxt  = p1_r;
        p1_nxt  = fill_word;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == IDX_MAX) begin
          idx_nxt   = IDX_MAX;
          state_nxt = S_WAIT;
        end
      end
      S_ERD: begin
        state_nxt = S_EWR;
      end
      S_EWR: begin
        wr_en   = 1'b1;
        wr_data = rd_data ^ seq_term;
        p2_nxt  = p1_r;
        p1_nxt  = rd_data ^ seq_term;
        ptr_nxt = ptr_r + 1'b1;
        state_nxt = (ptr_r == IDX_MAX) ? S_WAIT : S_ERD;
      end
      S_WAIT: begin
        if (!mod_rsp.busy) begin
          carry_nxt = mod_rsp.rem;
          if (warm_r != '0) begin
            kind_nxt  = DK_WARM;
            state_nxt = S_DRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      kind_r      <= DK_USER;
      idx_r       <= IDX_MAX;
      ptr_r       <= '0;
      carry_r     <= '0;
      warm_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      idx_r       <= idx_nxt;
      ptr_r       <= ptr_nxt;
      carry_r     <= carry_nxt;
      warm_r      <= warm_nxt;
      out_valid_r <= out_valid_nxt;
    end
    seed_r     <= seed_nxt;
    hi_r       <= hi_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    out_word_r <= out_word_nxt;
    out_par_r  <= out_par_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_rand_word   = out_word_r;
  assign out_word_parity = out_par_r;

  `LMWC_ASSERT_NOW(a_carry_range, 1'b1, carry_r < MWC_MULT, "carry out of range")
  `LMWC_ASSERT_NOW(a_hold_on_stall, user_stall, !wr_en, "table written while result blocked")
  `LMWC_ASSERT_NOW(a_idle_mod_done, in_ready, !mod_rsp.busy, "accept during carry reduction")
  `LMWC_ASSERT_NEXT(a_draw_to_mul, draw_fire, state_r == S_DMUL, "draw did not start")
  `LMWC_ASSERT_NEXT(a_draw_index, draw_fire, idx_r == $past(idx_inc), "index not advanced")
endmodule

// File: tb/lag256_multiply_with_carry_rng_tb.sv
module lag256_multiply_with_carry_rng_tb;
  import lmwc_pkg::*;

  localparam int RANDOM_ITEMS = 1050;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 600;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    bit [WORD_W-1:0] word;
    bit              parity;
  } draw_beat_t;

  class mwc_scoreboard;
    bit [WORD_W-1:0]  lag_words [TABLE_DEPTH];
    bit [CARRY_W-1:0] carry_q;
    bit [IDX_W-1:0]   idx_q;
    draw_beat_t       expected_draws[$];
    int               mismatches;

    function new();
      foreach (lag_words[i]) lag_words[i] = '0;
      carry_q     = '0;
      idx_q       = '1;
      mismatches  = 0;
    endfunction

    function bit [WORD_W-1:0] next_mwc_word();
      bit [63:0] t;
      idx_q = idx_q + 1'b1;
      t = 64'(MWC_MULT) * 64'(lag_words[idx_q]) + 64'(carry_q);
      carry_q = t[32 +: CARRY_W];
      lag_words[idx_q] = t[31:0];
      return t[31:0];
    endfunction

    function void reseed(bit [63:0] seed);
      bit [WORD_W-1:0] dummy;
      carry_q = CARRY_W'(seed % 64'(MWC_MULT));
      lag_words[0] = seed[31:0];
      lag_words[1] = seed[63:32];
      for (int i = 2; i < TABLE_DEPTH; i++)
        lag_words[i] = lag_words[i-2] * WORD_W'(LCG_MULT) + LCG_ADD;
      idx_q = '1;
      for (int i = 0; i < WARMUP_DRAWS; i++) dummy = next_mwc_word();
    endfunction

    function void mix_entropy(bit [63:0] seed);
      bit [WORD_W-1:0] hi;
      bit [WORD_W-1:0] lo;
      bit [63:0]       s;
      hi = next_mwc_word();
      lo = next_mwc_word();
      s = seed ^ {hi, lo};
      carry_q = CARRY_W'((64'(carry_q) ^ s) % 64'(MWC_MULT));
      lag_words[0] ^= s[31:0];
      lag_words[1] ^= s[63:32] ^ s[31:0];
      for (int i = 2; i < TABLE_DEPTH; i++)
        lag_words[i] ^= lag_words[i-2] * WORD_W'(LCG_MULT) + LCG_ADD;
    endfunction

    function void note_cmd(bit [1:0] cmd, bit [63:0] seed);
      draw_beat_t d;
      case (cmd)
        CMD_RESEED:  reseed(seed);
        CMD_ENTROPY: mix_entropy(seed);
        CMD_DRAW: begin
          d.word   = next_mwc_word();
          d.parity = ^d.word;
          expected_draws.push_back(d);
        end
        default: ;
      endcase
    endfunction

    function void check_draw(bit [WORD_W-1:0] word, bit parity);
      draw_beat_t d;
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected out beat: word %h parity %b", word, parity);
        return;
      end
      d = expected_draws.pop_front();
      if (word !== d.word || parity !== d.parity) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("draw mismatch: expected word %h parity %b, got word %h parity %b",
                   d.word, d.parity, word, parity);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_cmd = CMD_DRAW;
  logic [SEED_W-1:0] in_seed_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] out_rand_word;
  logic              out_word_parity;

  mwc_scoreboard sb = new();
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int quiet_cycles = 0;

  lag256_multiply_with_carry_rng u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rand_word   (out_rand_word),
    .out_word_parity (out_word_parity)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= (rcv_idle_pct == 0) || ($urandom_range(99) >= rcv_idle_pct);
  end

  // beat monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_draw(out_rand_word, out_word_parity);
      if (in_valid && in_ready) sb.note_cmd(in_cmd, in_seed_value);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("[lag256_multiply_with_carry_rng] ERROR");
      $finish;
    end
  end

  task automatic send_cmd(input logic [1:0] cmd, input logic [63:0] seed);
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_seed_value <= seed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_draws.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_cmd();
    int          pick;
    logic [1:0]  cmd;
    logic [63:0] seed;
    pick = $urandom_range(99);
    if (pick < 4)       cmd = CMD_RESEED;
    else if (pick < 8)  cmd = CMD_ENTROPY;
    else if (pick < 10) cmd = CMD_UNUSED;
    else                cmd = CMD_DRAW;
    seed = {$urandom, $urandom};
    send_cmd(cmd, seed);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // cleared table: draws return zero
    send_cmd(CMD_DRAW, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_DRAW, 64'h0123_4567_89AB_CDEF);
    send_cmd(CMD_RESEED, '0);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_RESEED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_RESEED, 64'(MWC_MULT) * 64'd5);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_RESEED, 64'(MWC_MULT) - 64'd1);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_ENTROPY, '0);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_ENTROPY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_DRAW, '0);
    send_cmd(CMD_ENTROPY, 64'hA5A5_5A5A_0F0F_F0F0);
    send_cmd(CMD_UNUSED, '0);
    send_cmd(CMD_DRAW, '0);
    wait_drained();

    snd_idle_pct = 29;
    rcv_idle_pct = 54;
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) send_random_cmd();
    wait_drained();

    snd_idle_pct = 54;
    rcv_idle_pct = 29;
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) send_random_cmd();
    wait_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) send_random_cmd();
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_draws.size() == 0) begin
      $display("[lag256_multiply_with_carry_rng] OK");
    end else begin
      $display("[lag256_multiply_with_carry_rng] ERROR");
    end
    $finish;
  end
endmodule
